@@ rtl/fptc_pkg.sv @@
// fptc_pkg: widths, codes, reset values and shared types of the fft peak tone classifier
// used by every module under rtl; depends on nothing
`default_nettype none

package fptc_pkg;

   // defaults for the top level parameters
   localparam int FFT_LENGTH_DEF         = 2048;
   localparam int FIRST_SEARCHED_BIN_DEF = 2;

   // field widths
   localparam int BIN_W      = 32;
   localparam int MAG_W      = 64;
   localparam int IDX_W      = 10;
   localparam int RATE_W     = 18;
   localparam int FREQ_W     = 21;
   localparam int CHOICE_W   = 3;
   localparam int NUM_TONES  = 5;
   localparam int PROD_W     = IDX_W + RATE_W;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 21;
   localparam int REQ_DATA_W = 64;
   localparam int RSP_DATA_W = 40;

   localparam int IDX_MAX_INT = (1 << IDX_W) - 1;
   localparam logic [IDX_W-1:0]  IDX_MAX  = '1;
   localparam logic [FREQ_W-1:0] FREQ_MAX = '1;

   localparam logic [CHOICE_W-1:0] CHOICE_INCONCLUSIVE = 3'd5;

   // register indexes on the csr port
   localparam logic [CSR_IDX_W-1:0] REG_AUDIO_RATE   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_REF_TONE_0   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_REF_TONE_1   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_REF_TONE_2   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_REF_TONE_3   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_REF_TONE_4   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_MATCH_WINDOW = 3'd6;

   // reset values
   localparam logic [RATE_W-1:0] AUDIO_RATE_RST   = 18'd48000;
   localparam logic [FREQ_W-1:0] REF_TONE_0_RST   = 21'd7040;
   localparam logic [FREQ_W-1:0] REF_TONE_1_RST   = 21'd9397;
   localparam logic [FREQ_W-1:0] REF_TONE_2_RST   = 21'd9956;
   localparam logic [FREQ_W-1:0] REF_TONE_3_RST   = 21'd11840;
   localparam logic [FREQ_W-1:0] REF_TONE_4_RST   = 21'd13290;
   localparam logic [FREQ_W-1:0] MATCH_WINDOW_RST = 21'd256;

   // squared parts of one bin, on their way to the peak tracker
   typedef struct packed {
      logic [MAG_W-1:0] re_sq;
      logic [MAG_W-1:0] im_sq;
      logic [IDX_W-1:0] idx;
      logic             searched;
      logic             last;
   } sq_bin_type;

   // configuration seen by the tone matcher
   typedef struct packed {
      logic [RATE_W-1:0]                  audio_rate;
      logic [NUM_TONES-1:0][FREQ_W-1:0]   ref_tone;
      logic [FREQ_W-1:0]                  match_window;
   } cfg_type;

endpackage

`default_nettype wire

@@ rtl/fptc_bin_front.sv @@
// fptc_bin_front: bin counter, input register and squaring stage
// depends on fptc_pkg
`default_nettype none

module fptc_bin_front #(
   parameter int FFT_LENGTH         = fptc_pkg::FFT_LENGTH_DEF,
   parameter int FIRST_SEARCHED_BIN = fptc_pkg::FIRST_SEARCHED_BIN_DEF
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_tvalid,
   output      logic                        req_tready,
   input  wire logic [fptc_pkg::BIN_W-1:0]  bin_real,
   input  wire logic [fptc_pkg::BIN_W-1:0]  bin_imag,
   input  wire logic                        last_bin,
   output      logic                        sq_valid,
   input  wire logic                        sq_ready,
   output      fptc_pkg::sq_bin_type        sq_bin
);

   localparam int LIMIT_INT = (FFT_LENGTH / 2 > fptc_pkg::IDX_MAX_INT) ?
                              fptc_pkg::IDX_MAX_INT : FFT_LENGTH / 2;
   localparam logic [fptc_pkg::IDX_W-1:0] LIMIT_IDX = fptc_pkg::IDX_W'(LIMIT_INT);
   localparam logic [fptc_pkg::IDX_W-1:0] FIRST_IDX = fptc_pkg::IDX_W'(FIRST_SEARCHED_BIN);

   logic [fptc_pkg::IDX_W-1:0] bin_count_ff, bin_count_in;
   logic                       s0_valid_ff, s0_valid_in;
   logic [fptc_pkg::BIN_W-1:0] s0_real_ff, s0_imag_ff;
   logic [fptc_pkg::IDX_W-1:0] s0_idx_ff;
   logic                       s0_search_ff, s0_last_ff;
   logic                       s1_valid_ff, s1_valid_in;
   fptc_pkg::sq_bin_type       s1_bin_ff, s1_bin_in;

   logic                       s0_ready, s1_ready, accept, s0_move;
   logic [fptc_pkg::BIN_W-1:0] abs_re, abs_im;

   assign s1_ready   = !s1_valid_ff || sq_ready;
   assign s0_ready   = !s0_valid_ff || s1_ready;
   assign req_tready = s0_ready;
   assign accept     = req_tvalid && s0_ready;
   assign s0_move    = s0_valid_ff && s1_ready;

   // bin index saturates on an overlong frame and restarts after the last bin
   always_comb begin
      bin_count_in = bin_count_ff;
      if (accept) begin
         if (last_bin) begin
            bin_count_in = '0;
         end else if (bin_count_ff != fptc_pkg::IDX_MAX) begin
            bin_count_in = bin_count_ff + fptc_pkg::IDX_W'(1);
         end
      end
   end

   // most negative value maps onto 2^31 as unsigned
   assign abs_re = s0_real_ff[fptc_pkg::BIN_W-1] ? (~s0_real_ff + fptc_pkg::BIN_W'(1))
                                                 : s0_real_ff;
   assign abs_im = s0_imag_ff[fptc_pkg::BIN_W-1] ? (~s0_imag_ff + fptc_pkg::BIN_W'(1))
                                                 : s0_imag_ff;

   always_comb begin
      s1_bin_in.re_sq    = fptc_pkg::MAG_W'(abs_re) * fptc_pkg::MAG_W'(abs_re);
      s1_bin_in.im_sq    = fptc_pkg::MAG_W'(abs_im) * fptc_pkg::MAG_W'(abs_im);
      s1_bin_in.idx      = s0_idx_ff;
      s1_bin_in.searched = s0_search_ff;
      s1_bin_in.last     = s0_last_ff;
   end

   assign s0_valid_in = accept || (s0_valid_ff && !s1_ready);
   assign s1_valid_in = s0_move || (s1_valid_ff && !sq_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         bin_count_ff <= '0;
         s0_valid_ff  <= 1'b0;
         s1_valid_ff  <= 1'b0;
      end else begin
         bin_count_ff <= bin_count_in;
         s0_valid_ff  <= s0_valid_in;
         s1_valid_ff  <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s0_real_ff   <= bin_real;
         s0_imag_ff   <= bin_imag;
         s0_idx_ff    <= bin_count_ff;
         s0_search_ff <= (bin_count_ff >= FIRST_IDX) && (bin_count_ff < LIMIT_IDX);
         s0_last_ff   <= last_bin;
      end
      if (s0_move) begin
         s1_bin_ff <= s1_bin_in;
      end
   end

   assign sq_valid = s1_valid_ff;
   assign sq_bin   = s1_bin_ff;

endmodule

`default_nettype wire

@@ rtl/fptc_peak_track.sv @@
// fptc_peak_track: running maximum of squared magnitude over one frame, hands the
// peak index on at the last bin; depends on fptc_pkg
`default_nettype none

module fptc_peak_track #(
   parameter int FFT_LENGTH = fptc_pkg::FFT_LENGTH_DEF
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        sq_valid,
   output      logic                        sq_ready,
   input  wire fptc_pkg::sq_bin_type        sq_bin,
   output      logic                        peak_valid,
   input  wire logic                        peak_ready,
   output      logic [fptc_pkg::IDX_W-1:0]  peak_idx
);

   localparam int LIMIT_INT = (FFT_LENGTH / 2 > fptc_pkg::IDX_MAX_INT) ?
                              fptc_pkg::IDX_MAX_INT : FFT_LENGTH / 2;

   logic [fptc_pkg::MAG_W-1:0] best_mag_ff, best_mag_in;
   logic [fptc_pkg::IDX_W-1:0] best_idx_ff, best_idx_in;
   logic                       r1_valid_ff, r1_valid_in;
   logic [fptc_pkg::IDX_W-1:0] r1_idx_ff;

   logic                       r1_ready, consume, take;
   logic [fptc_pkg::MAG_W-1:0] mag;
   logic [fptc_pkg::IDX_W-1:0] final_idx;

   assign r1_ready = !r1_valid_ff || peak_ready;
   // an ordinary bin never waits, only a frame end needs room downstream
   assign sq_ready = !sq_bin.last || r1_ready;
   assign consume  = sq_valid && sq_ready;

   assign mag       = sq_bin.re_sq + sq_bin.im_sq;
   assign take      = sq_bin.searched && (mag > best_mag_ff);
   assign final_idx = take ? sq_bin.idx : best_idx_ff;

   always_comb begin
      best_mag_in = best_mag_ff;
      best_idx_in = best_idx_ff;
      if (consume) begin
         if (sq_bin.last) begin
            best_mag_in = '0;
            best_idx_in = '0;
         end else if (take) begin
            best_mag_in = mag;
            best_idx_in = sq_bin.idx;
         end
      end
   end

   assign r1_valid_in = (consume && sq_bin.last) || (r1_valid_ff && !peak_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         best_mag_ff <= '0;
         best_idx_ff <= '0;
         r1_valid_ff <= 1'b0;
      end else begin
         best_mag_ff <= best_mag_in;
         best_idx_ff <= best_idx_in;
         r1_valid_ff <= r1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (consume && sq_bin.last) begin
         r1_idx_ff <= final_idx;
      end
   end

   assign peak_valid = r1_valid_ff;
   assign peak_idx   = r1_idx_ff;

   a_clear_after_frame: assert property (@(posedge clock) disable iff (reset)
      consume && sq_bin.last |=> best_mag_ff == '0 && best_idx_ff == '0)
      else $error("frame state not cleared after last bin");

   a_idx_has_mag: assert property (@(posedge clock) disable iff (reset)
      best_idx_ff != '0 |-> best_mag_ff != '0)
      else $error("peak index held with zero magnitude");

   a_peak_in_range: assert property (@(posedge clock) disable iff (reset)
      r1_valid_ff |-> r1_idx_ff < fptc_pkg::IDX_W'(LIMIT_INT) || r1_idx_ff == '0)
      else $error("peak index outside searched range");

endmodule

`default_nettype wire

@@ rtl/fptc_tone_match.sv @@
// fptc_tone_match: peak index to frequency, nearest reference tone and result register
// depends on fptc_pkg
`default_nettype none

module fptc_tone_match #(
   parameter int FFT_LENGTH = fptc_pkg::FFT_LENGTH_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire fptc_pkg::cfg_type              cfg,
   input  wire logic                           peak_valid,
   output      logic                           peak_ready,
   input  wire logic [fptc_pkg::IDX_W-1:0]     peak_idx,
   output      logic                           res_valid,
   input  wire logic                           res_ready,
   output      logic [fptc_pkg::FREQ_W-1:0]    res_freq,
   output      logic [fptc_pkg::IDX_W-1:0]     res_bin,
   output      logic [fptc_pkg::CHOICE_W-1:0]  res_choice
);

   localparam int FFT_LOG2 = $clog2(FFT_LENGTH);
   localparam int NUM_W    = fptc_pkg::PROD_W + 5;
   localparam logic [NUM_W-1:0] HALF_LEN = NUM_W'(FFT_LENGTH / 2);

   logic                          r2_valid_ff, r3_valid_ff, r4_valid_ff, out_valid_ff;
   logic [fptc_pkg::PROD_W-1:0]   r2_prod_ff;
   logic [fptc_pkg::IDX_W-1:0]    r2_idx_ff, r3_idx_ff, r4_idx_ff, out_idx_ff;
   logic [fptc_pkg::FREQ_W-1:0]   r3_freq_ff, r4_freq_ff, out_freq_ff;
   logic [fptc_pkg::NUM_TONES-1:0][fptc_pkg::FREQ_W-1:0] r4_dist_ff, r4_dist_in;
   logic [fptc_pkg::CHOICE_W-1:0] out_choice_ff, out_choice_in;
   logic [fptc_pkg::FREQ_W-1:0]   r3_freq_in;

   logic r2_ready, r3_ready, r4_ready, out_ready;
   logic [NUM_W-1:0]              num, quot;
   logic [fptc_pkg::FREQ_W-1:0]   min_dist;

   assign out_ready  = !out_valid_ff || res_ready;
   assign r4_ready   = !r4_valid_ff || out_ready;
   assign r3_ready   = !r3_valid_ff || r4_ready;
   assign r2_ready   = !r2_valid_ff || r3_ready;
   assign peak_ready = r2_ready;

   // round to nearest: (idx * rate * 16 + len/2) / len, len a power of two
   assign num  = {1'b0, r2_prod_ff, 4'b0000} + HALF_LEN;
   assign quot = num >> FFT_LOG2;
   assign r3_freq_in = (quot > NUM_W'(fptc_pkg::FREQ_MAX)) ? fptc_pkg::FREQ_MAX
                                                            : quot[fptc_pkg::FREQ_W-1:0];

   always_comb begin
      for (int k = 0; k < fptc_pkg::NUM_TONES; k++) begin
         r4_dist_in[k] = (r3_freq_ff >= cfg.ref_tone[k]) ? r3_freq_ff - cfg.ref_tone[k]
                                                         : cfg.ref_tone[k] - r3_freq_ff;
      end
   end

   // earliest tone wins a tie
   always_comb begin
      min_dist      = r4_dist_ff[0];
      out_choice_in = '0;
      for (int k = 1; k < fptc_pkg::NUM_TONES; k++) begin
         if (r4_dist_ff[k] < min_dist) begin
            min_dist      = r4_dist_ff[k];
            out_choice_in = fptc_pkg::CHOICE_W'(k);
         end
      end
      if (min_dist >= cfg.match_window) begin
         out_choice_in = fptc_pkg::CHOICE_INCONCLUSIVE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         r2_valid_ff  <= 1'b0;
         r3_valid_ff  <= 1'b0;
         r4_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (r2_ready) begin
            r2_valid_ff <= peak_valid;
         end
         if (r3_ready) begin
            r3_valid_ff <= r2_valid_ff;
         end
         if (r4_ready) begin
            r4_valid_ff <= r3_valid_ff;
         end
         if (out_ready) begin
            out_valid_ff <= r4_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (r2_ready && peak_valid) begin
         r2_prod_ff <= fptc_pkg::PROD_W'(peak_idx) * fptc_pkg::PROD_W'(cfg.audio_rate);
         r2_idx_ff  <= peak_idx;
      end
      if (r3_ready && r2_valid_ff) begin
         r3_freq_ff <= r3_freq_in;
         r3_idx_ff  <= r2_idx_ff;
      end
      if (r4_ready && r3_valid_ff) begin
         r4_dist_ff <= r4_dist_in;
         r4_freq_ff <= r3_freq_ff;
         r4_idx_ff  <= r3_idx_ff;
      end
      if (out_ready && r4_valid_ff) begin
         out_freq_ff   <= r4_freq_ff;
         out_idx_ff    <= r4_idx_ff;
         out_choice_ff <= out_choice_in;
      end
   end

   assign res_valid  = out_valid_ff;
   assign res_freq   = out_freq_ff;
   assign res_bin    = out_idx_ff;
   assign res_choice = out_choice_ff;

   a_choice_code: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> out_choice_ff <= fptc_pkg::CHOICE_INCONCLUSIVE)
      else $error("tone choice outside its codes");

   a_pipe_moves: assert property (@(posedge clock) disable iff (reset)
      r4_valid_ff && out_ready |=> out_valid_ff)
      else $error("result lost between distance stage and output");

endmodule

`default_nettype wire

@@ rtl/fft_peak_tone_classifier.sv @@
// throughput: one bin per cycle while the output is not stalled; the squaring stage and
// the peak compare each take one stage, and up to four frame results queue in the tone
// matching pipeline
// reset: synchronous; frame state and valid bits clear, registers take their defaults
// fft_peak_tone_classifier: top level, csr registers and stream ports; depends on fptc_pkg,
// fptc_bin_front, fptc_peak_track and fptc_tone_match
`default_nettype none

module fft_peak_tone_classifier #(
   parameter int FFT_LENGTH         = fptc_pkg::FFT_LENGTH_DEF,
   parameter int FIRST_SEARCHED_BIN = fptc_pkg::FIRST_SEARCHED_BIN_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // bin_real [31:0], bin_imag [63:32]
   input  wire logic [fptc_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  wire logic                              req_tlast,
   input  wire logic                              req_tvalid,
   output      logic                              req_tready,
   // dominant_freq [20:0], peak_bin [30:21], tone_choice [33:31], zeros above
   output      logic [fptc_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output      logic                              rsp_tvalid,
   input  wire logic                              rsp_tready,
   input  wire logic                              csr_we,
   input  wire logic [fptc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [fptc_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   fptc_pkg::cfg_type    cfg_ff, cfg_in;
   logic                 sq_valid, sq_ready, peak_valid, peak_ready;
   fptc_pkg::sq_bin_type sq_bin;
   logic [fptc_pkg::IDX_W-1:0]    peak_idx, res_bin;
   logic [fptc_pkg::FREQ_W-1:0]   res_freq;
   logic [fptc_pkg::CHOICE_W-1:0] res_choice;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            fptc_pkg::REG_AUDIO_RATE:
               cfg_in.audio_rate = csr_wdata[fptc_pkg::RATE_W-1:0];
            fptc_pkg::REG_REF_TONE_0: cfg_in.ref_tone[0] = csr_wdata;
            fptc_pkg::REG_REF_TONE_1: cfg_in.ref_tone[1] = csr_wdata;
            fptc_pkg::REG_REF_TONE_2: cfg_in.ref_tone[2] = csr_wdata;
            fptc_pkg::REG_REF_TONE_3: cfg_in.ref_tone[3] = csr_wdata;
            fptc_pkg::REG_REF_TONE_4: cfg_in.ref_tone[4] = csr_wdata;
            fptc_pkg::REG_MATCH_WINDOW: cfg_in.match_window = csr_wdata;
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.audio_rate   <= fptc_pkg::AUDIO_RATE_RST;
         cfg_ff.ref_tone[0]  <= fptc_pkg::REF_TONE_0_RST;
         cfg_ff.ref_tone[1]  <= fptc_pkg::REF_TONE_1_RST;
         cfg_ff.ref_tone[2]  <= fptc_pkg::REF_TONE_2_RST;
         cfg_ff.ref_tone[3]  <= fptc_pkg::REF_TONE_3_RST;
         cfg_ff.ref_tone[4]  <= fptc_pkg::REF_TONE_4_RST;
         cfg_ff.match_window <= fptc_pkg::MATCH_WINDOW_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   fptc_bin_front #(
      .FFT_LENGTH         (FFT_LENGTH),
      .FIRST_SEARCHED_BIN (FIRST_SEARCHED_BIN)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .bin_real   (req_tdata[fptc_pkg::BIN_W-1:0]),
      .bin_imag   (req_tdata[2*fptc_pkg::BIN_W-1:fptc_pkg::BIN_W]),
      .last_bin   (req_tlast),
      .sq_valid   (sq_valid),
      .sq_ready   (sq_ready),
      .sq_bin     (sq_bin)
   );

   fptc_peak_track #(
      .FFT_LENGTH (FFT_LENGTH)
   ) u_track (
      .clock      (clock),
      .reset      (reset),
      .sq_valid   (sq_valid),
      .sq_ready   (sq_ready),
      .sq_bin     (sq_bin),
      .peak_valid (peak_valid),
      .peak_ready (peak_ready),
      .peak_idx   (peak_idx)
   );

   fptc_tone_match #(
      .FFT_LENGTH (FFT_LENGTH)
   ) u_match (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .peak_valid (peak_valid),
      .peak_ready (peak_ready),
      .peak_idx   (peak_idx),
      .res_valid  (rsp_tvalid),
      .res_ready  (rsp_tready),
      .res_freq   (res_freq),
      .res_bin    (res_bin),
      .res_choice (res_choice)
   );

   assign rsp_tdata = {
      (fptc_pkg::RSP_DATA_W - fptc_pkg::FREQ_W - fptc_pkg::IDX_W - fptc_pkg::CHOICE_W)'(0),
      res_choice, res_bin, res_freq
   };

endmodule

`default_nettype wire
